/* rtl/core/mfpr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mfpr_pkg
// Shared types and constants for the marker framed packet receiver.
// ----------------------------------------------------------------------------
package mfpr_pkg;

    localparam int unsigned MARKER_W   = 32;
    localparam int unsigned SIZE_W     = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [MARKER_W-1:0] START_MARKER_RESET = '0;
    localparam logic [SIZE_W-1:0]   MAX_PAYLOAD_RESET  = 16'd1024;

    // Header field lengths in bytes
    localparam logic [SIZE_W-1:0]   HDR_FIELD_BYTES    = 16'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARKER = 2'd0,
        CFG_MAX_PAYLOAD  = 2'd1
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_SIZE = 4'b0010,
        PH_CSUM = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

endpackage : mfpr_pkg
`default_nettype wire

/* rtl/core/marker_framed_packet_receiver_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// marker_framed_packet_receiver_unit
// Hunts a 32-bit start marker in the byte stream, then parses size, checksum
// and payload, streaming payload bytes out with their index.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  in       | input     | in_valid / in_stall  | rx_byte
//  out      | output    | out_valid / out_stall| payload_*, frame_*
//  cfg      | input     | cfg_wr_en            | cfg_index, cfg_wdata
//
//  One beat per cycle: each input beat updates the parser state and loads the
//  result register in the cycle it is accepted; its result shows the cycle after.
//  The single output register lets a new beat in whenever it is empty or
//  being drained in the same cycle; in_stall rises only on a held result.
//  Reset clears the parser to idle and the registers to marker 0, size 1024.
// ----------------------------------------------------------------------------
module marker_framed_packet_receiver_unit
    import mfpr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [BYTE_W-1:0]     rx_byte,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       payload_valid,
    output logic [BYTE_W-1:0]          payload_byte,
    output logic [SIZE_W-1:0]          payload_index,
    output logic                       frame_done,
    output logic                       frame_good,
    output logic                       frame_aborted,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [MARKER_W-1:0]   cfg_wdata
);

    logic [MARKER_W-1:0] start_marker_reg;
    logic [SIZE_W-1:0]   max_payload_reg;

    logic [MARKER_W-1:0] window_reg,     window_next;
    phase_t              phase_reg,      phase_next;
    logic [SIZE_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [SIZE_W-1:0]   frame_size_reg, frame_size_next;
    logic [SIZE_W-1:0]   csum_reg,       csum_next;
    logic [SIZE_W-1:0]   sum_reg,        sum_next;
    logic [SIZE_W-1:0]   pos_reg,        pos_next;
    logic                good_reg,       good_next;

    logic                out_valid_reg;
    logic                pvalid_reg,     pvalid_next;
    logic [BYTE_W-1:0]   pbyte_reg,      pbyte_next;
    logic [SIZE_W-1:0]   pindex_reg,     pindex_next;
    logic                done_reg,       done_next;
    logic                aborted_reg,    aborted_next;

    logic                in_accept;
    logic [MARKER_W-1:0] shifted;
    logic [SIZE_W-1:0]   bl_dec;
    logic                bl_last;
    logic [SIZE_W-1:0]   size_sh;
    logic [SIZE_W-1:0]   csum_sh;
    logic [SIZE_W-1:0]   sum_add;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    assign shifted = {window_reg[MARKER_W-BYTE_W-1:0], rx_byte};
    assign bl_dec  = bytes_left_reg - 16'd1;
    assign bl_last = (bl_dec == '0);
    assign size_sh = {frame_size_reg[SIZE_W-BYTE_W-1:0], rx_byte};
    assign csum_sh = {csum_reg[SIZE_W-BYTE_W-1:0], rx_byte};
    assign sum_add = sum_reg + {{(SIZE_W-BYTE_W){1'b0}}, rx_byte};

    always_comb
    begin
        window_next     = shifted;
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        frame_size_next = frame_size_reg;
        csum_next       = csum_reg;
        sum_next        = sum_reg;
        pos_next        = pos_reg;
        good_next       = good_reg;
        pvalid_next     = 1'b0;
        pbyte_next      = '0;
        pindex_next     = '0;
        done_next       = 1'b0;
        aborted_next    = 1'b0;

        if (shifted == start_marker_reg)
        begin
            // marker restarts the frame, window included
            window_next     = '0;
            phase_next      = PH_SIZE;
            bytes_left_next = HDR_FIELD_BYTES;
            frame_size_next = '0;
            csum_next       = '0;
            sum_next        = '0;
            pos_next        = '0;
            good_next       = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_SIZE:
                begin
                    frame_size_next = size_sh;
                    bytes_left_next = bl_dec;
                    if (bl_last)
                    begin
                        if (size_sh > max_payload_reg)
                        begin
                            window_next     = '0;
                            phase_next      = PH_IDLE;
                            bytes_left_next = '0;
                            frame_size_next = '0;
                            csum_next       = '0;
                            sum_next        = '0;
                            pos_next        = '0;
                            good_next       = 1'b0;
                            aborted_next    = 1'b1;
                        end
                        else
                        begin
                            phase_next      = PH_CSUM;
                            bytes_left_next = HDR_FIELD_BYTES;
                        end
                    end
                end
                PH_CSUM:
                begin
                    csum_next       = csum_sh;
                    bytes_left_next = bl_dec;
                    if (bl_last)
                    begin
                        if (frame_size_reg != '0)
                        begin
                            phase_next      = PH_DATA;
                            bytes_left_next = frame_size_reg;
                        end
                        else
                        begin
                            if (csum_sh == '0)
                                good_next = 1'b1;
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                end
                PH_DATA:
                begin
                    pvalid_next     = 1'b1;
                    pbyte_next      = rx_byte;
                    pindex_next     = pos_reg;
                    pos_next        = pos_reg + 16'd1;
                    sum_next        = sum_add;
                    bytes_left_next = bl_dec;
                    if (bl_last)
                    begin
                        if ((16'd0 - sum_add) == csum_reg)
                            good_next = 1'b1;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RESET;
            max_payload_reg  <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_START_MARKER: start_marker_reg <= cfg_wdata;
                CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_wdata[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= '0;
            frame_size_reg <= '0;
            csum_reg       <= '0;
            sum_reg        <= '0;
            pos_reg        <= '0;
            good_reg       <= 1'b0;
        end
        else if (in_accept)
        begin
            window_reg     <= window_next;
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            frame_size_reg <= frame_size_next;
            csum_reg       <= csum_next;
            sum_reg        <= sum_next;
            pos_reg        <= pos_next;
            good_reg       <= good_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pvalid_reg  <= pvalid_next;
            pbyte_reg   <= pbyte_next;
            pindex_reg  <= pindex_next;
            done_reg    <= done_next;
            aborted_reg <= aborted_next;
        end
    end

    // the good flag after this beat is the registered state itself
    assign out_valid     = out_valid_reg;
    assign payload_valid = pvalid_reg;
    assign payload_byte  = pbyte_reg;
    assign payload_index = pindex_reg;
    assign frame_done    = done_reg;
    assign frame_good    = good_reg;
    assign frame_aborted = aborted_reg;

endmodule : marker_framed_packet_receiver_unit
`default_nettype wire

/* rtl/core/mfpr_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mfpr_checker
// Port-level checks on the marker framed packet receiver.
// ----------------------------------------------------------------------------
module mfpr_checker
    import mfpr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [BYTE_W-1:0]     rx_byte,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic                  payload_valid,
    input  wire logic [BYTE_W-1:0]     payload_byte,
    input  wire logic [SIZE_W-1:0]     payload_index,
    input  wire logic                  frame_done,
    input  wire logic                  frame_good,
    input  wire logic                  frame_aborted,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [MARKER_W-1:0]   cfg_wdata
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_valid)
            && $stable(payload_byte) && $stable(payload_index)
            && $stable(frame_done) && $stable(frame_aborted))
        else $error("held result beat changed");

    // input only backs up behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free result register");

    // non-payload beats carry zero byte and index
    a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> payload_byte == '0 && payload_index == '0)
        else $error("payload fields set on non-payload beat");

    // an abort clears everything and never coincides with data or completion
    a_abort: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_aborted |-> !payload_valid && !frame_done && !frame_good)
        else $error("abort beat with data, completion or good flag");

    // an accepted input beat always yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted beat produced no result");

endmodule : mfpr_checker

bind marker_framed_packet_receiver_unit mfpr_checker u_mfpr_checker (.*);
`default_nettype wire
